### sv/stse_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine package
// Shared constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stse_pkg;

   // Default table depth and fixed field widths.
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_W           = 63;
   localparam int VALUE_W         = 64;
   localparam int FUNC_W          = 4;

   // Value reported when no timestamp is present.
   localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

   // Request codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT       = 4'd0,
      FUNC_REMOVE_BELOW = 4'd1,
      FUNC_LIST_BELOW   = 4'd2,
      FUNC_LIST_RANGE   = 4'd3,
      FUNC_NEAREST      = 4'd4,
      FUNC_LATEST       = 4'd5,
      FUNC_EARLIEST     = 4'd6,
      FUNC_COUNT        = 4'd7,
      FUNC_CLEAR        = 4'd8,
      FUNC_CONTAINS     = 4'd9
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic do_cmp;
      logic exec_emit;
      logic shift_step;
      logic shift_emit;
      logic list_load;
      logic list_emit;
      logic near_load;
      logic near_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              out_free;
      logic              shift_more;
      logic              list_last;
   } status_type;

endpackage

### sv/stse_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine controller
// Sequences compare, execute, shift, list and nearest phases of a request.
// ----------------------------------------------------------------------------
module stse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stse_pkg::status_type status,
   output stse_pkg::cmd_type    cmd
);
   import stse_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CMP   = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_LIST  = 6'b010000,
      ST_NEAR  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // A new request is taken only while idle.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.do_cmp = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            case (status.func)
               FUNC_REMOVE_BELOW: state_in = ST_SHIFT;
               FUNC_LIST_BELOW, FUNC_LIST_RANGE: begin
                  cmd.list_load = 1'b1;
                  state_in      = ST_LIST;
               end
               FUNC_NEAREST: begin
                  cmd.near_load = 1'b1;
                  state_in      = ST_NEAR;
               end
               default: begin
                  if (status.out_free) begin
                     cmd.exec_emit = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SHIFT: begin
            if (status.shift_more) begin
               cmd.shift_step = 1'b1;
            end else if (status.out_free) begin
               cmd.shift_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (status.out_free) begin
               cmd.list_emit = 1'b1;
               if (status.list_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NEAR: begin
            if (status.out_free) begin
               cmd.near_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/stse_datapath.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine datapath
// Row of sorted key cells with parallel compares, shift logic and result register.
// ----------------------------------------------------------------------------
module stse_datapath #(
   parameter int TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF,
   parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [stse_pkg::FUNC_W-1:0]   req_func,
   input  logic [stse_pkg::KEY_W-1:0]    req_key,
   input  logic [stse_pkg::KEY_W-1:0]    req_key_end,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [stse_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_has_value,
   output logic [CW-1:0]                 rsp_tally,
   output logic                          rsp_found,
   output logic                          rsp_full_drop,
   output logic                          rsp_last,
   input  stse_pkg::cmd_type             cmd,
   output stse_pkg::status_type          status
);
   import stse_pkg::*;

   // Request operands.
   logic [FUNC_W-1:0] func_ff;
   logic [KEY_W-1:0]  key_ff, end_ff;

   // Key cells and fill count.
   logic [KEY_W-1:0] cell_ff [TABLE_DEPTH];
   logic [KEY_W-1:0] cell_in [TABLE_DEPTH];
   logic [CW-1:0]    count_ff, count_in;

   // Registered compare vectors.
   logic [TABLE_DEPTH-1:0] lt_ff, le_ff, eq_ff, valid_vec;
   logic [TABLE_DEPTH-1:0] lt_in, le_in, eq_in;

   // List mask, nearest candidates and remove tally.
   logic [TABLE_DEPTH-1:0] mask_ff, mask_in, mask_low, mask_rest;
   logic [KEY_W-1:0]       lo_ff, hi_ff, lo_in, hi_in;
   logic                   has_lo_ff, has_hi_ff;
   logic [TABLE_DEPTH-1:0] lo_sel, hi_sel;
   logic [CW-1:0]          tally_ff, tally_in;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_has_ff, out_has_in;
   logic [CW-1:0]      out_tally_ff, out_tally_in;
   logic               out_found_ff, out_found_in;
   logic               out_drop_ff, out_drop_in;
   logic               out_last_ff, out_last_in;

   // Helper terms.
   logic             out_free, any_eq, table_full, do_insert, pick_lo;
   logic [KEY_W-1:0] list_val, latest_val;
   logic [VALUE_W-1:0] pair_sum, twice_key;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign any_eq     = |eq_ff;
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign do_insert  = cmd.exec_emit && (func_ff == FUNC_INSERT) && !any_eq && !table_full;

   // Occupancy and parallel compares against the current cells.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid_vec[i] = (CW'(i) < count_ff);
         lt_in[i]     = valid_vec[i] && (cell_ff[i] < key_ff);
         le_in[i]     = valid_vec[i] && (cell_ff[i] <= end_ff);
         eq_in[i]     = valid_vec[i] && (cell_ff[i] == key_ff);
      end
   end

   // List selection: lowest remaining match and the matches after it.
   assign mask_low  = mask_ff & (~mask_ff + TABLE_DEPTH'(1));
   assign mask_rest = mask_ff & ~mask_low;

   // Nearest candidates, latest key and listed key by one-hot selection.
   always_comb begin
      list_val   = '0;
      latest_val = '0;
      lo_in      = '0;
      hi_in      = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hi_sel[i] = valid_vec[i] && !lt_ff[i] && ((i == 0) || lt_ff[(i == 0) ? 0 : i-1]);
         lo_sel[i] = lt_ff[i] &&
                     ((i == TABLE_DEPTH-1) || !lt_ff[(i == TABLE_DEPTH-1) ? i : i+1]);
         if (mask_low[i])                  list_val   = list_val   | cell_ff[i];
         if (CW'(i + 1) == count_ff)       latest_val = latest_val | cell_ff[i];
         if (lo_sel[i])                    lo_in      = lo_in      | cell_ff[i];
         if (hi_sel[i])                    hi_in      = hi_in      | cell_ff[i];
      end
   end

   // Tie goes to the lower key: key - lo <= hi - key.
   assign pair_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign twice_key = {key_ff, 1'b0};
   assign pick_lo   = (twice_key <= pair_sum);

   // Cell updates: insert shifts up behind the slot, remove shifts down, clear zeroes the count.
   always_comb begin
      count_in = count_ff;
      tally_in = tally_ff;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.load_req) begin
         tally_in = '0;
      end
      if (do_insert) begin
         count_in = count_ff + CW'(1);
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!lt_ff[i]) begin
               if ((i == 0) || lt_ff[(i == 0) ? 0 : i-1]) begin
                  cell_in[i] = key_ff;
               end else begin
                  cell_in[i] = cell_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end
      if (cmd.shift_step) begin
         count_in = count_ff - CW'(1);
         tally_in = tally_ff + CW'(1);
         for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
      if (cmd.exec_emit && (func_ff == FUNC_CLEAR)) begin
         count_in = '0;
      end
   end

   // List mask load and consumption.
   always_comb begin
      mask_in = mask_ff;
      if (cmd.list_load) begin
         mask_in = (func_ff == FUNC_LIST_BELOW) ? lt_ff : (~lt_ff & le_ff);
      end else if (cmd.list_emit) begin
         mask_in = mask_rest;
      end
   end

   // Result composition.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_has_in   = out_has_ff;
      out_tally_in = out_tally_ff;
      out_found_in = out_found_ff;
      out_drop_in  = out_drop_ff;
      out_last_in  = out_last_ff;
      if (cmd.exec_emit || cmd.shift_emit || cmd.list_emit || cmd.near_emit) begin
         out_valid_in = 1'b1;
         out_value_in = NONE_VALUE;
         out_has_in   = 1'b0;
         out_tally_in = '0;
         out_found_in = 1'b0;
         out_drop_in  = 1'b0;
         out_last_in  = 1'b1;
         if (cmd.exec_emit) begin
            case (func_ff)
               FUNC_INSERT:   out_drop_in = !any_eq && table_full;
               FUNC_COUNT:    out_tally_in = count_ff;
               FUNC_CONTAINS: out_found_in = any_eq;
               FUNC_LATEST: begin
                  if (count_ff != '0) begin
                     out_has_in   = 1'b1;
                     out_value_in = {1'b0, latest_val};
                  end
               end
               FUNC_EARLIEST: begin
                  if (count_ff != '0) begin
                     out_has_in   = 1'b1;
                     out_value_in = {1'b0, cell_ff[0]};
                  end
               end
               default: out_last_in = 1'b1;
            endcase
         end
         if (cmd.shift_emit) begin
            out_tally_in = tally_ff;
         end
         if (cmd.list_emit && (mask_ff != '0)) begin
            out_has_in   = 1'b1;
            out_value_in = {1'b0, list_val};
            out_last_in  = (mask_rest == '0);
         end
         if (cmd.near_emit && (has_lo_ff || has_hi_ff)) begin
            out_has_in = 1'b1;
            if (has_lo_ff && (!has_hi_ff || pick_lo)) begin
               out_value_in = {1'b0, lo_ff};
            end else begin
               out_value_in = {1'b0, hi_ff};
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         end_ff  <= req_key_end;
      end
      if (cmd.do_cmp) begin
         lt_ff <= lt_in;
         le_ff <= le_in;
         eq_ff <= eq_in;
      end
      if (cmd.near_load) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         has_lo_ff <= |lo_sel;
         has_hi_ff <= |hi_sel;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      mask_ff      <= mask_in;
      tally_ff     <= tally_in;
      out_value_ff <= out_value_in;
      out_has_ff   <= out_has_in;
      out_tally_ff <= out_tally_in;
      out_found_ff <= out_found_in;
      out_drop_ff  <= out_drop_in;
      out_last_ff  <= out_last_in;
   end

   // Status and ports.
   assign status.func       = func_ff;
   assign status.out_free   = out_free;
   assign status.shift_more = (count_ff != '0) && (cell_ff[0] < key_ff);
   assign status.list_last  = (mask_rest == '0);

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_has_value = out_has_ff;
   assign rsp_tally     = out_tally_ff;
   assign rsp_found     = out_found_ff;
   assign rsp_full_drop = out_drop_ff;
   assign rsp_last      = out_last_ff;

endmodule

### sv/sorted_timestamp_set_engine_core.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine core
// Ascending set of unique timestamps with insert, remove, list and search.
// ----------------------------------------------------------------------------
// A request passes through idle (accept), compare and execute; nearest and list
// requests then load their candidates or mask, and remove_below shifts out one key per step.
// List requests then give one result per cycle while the output is not stalled.
// Requests are handled one at a time (idle, compare, execute, then any further phase);
// the next is taken once the current one has issued its last result into the
// output register. Reset empties the table.
module sorted_timestamp_set_engine_core #(
   parameter int TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF,
   parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [stse_pkg::FUNC_W-1:0]   req_func,
   input  logic [stse_pkg::KEY_W-1:0]    req_key,
   input  logic [stse_pkg::KEY_W-1:0]    req_key_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [stse_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_has_value,
   output logic [CW-1:0]                 rsp_tally,
   output logic                          rsp_found,
   output logic                          rsp_full_drop,
   output logic                          rsp_last
);
   import stse_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Request sequencer.
   stse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Key table and result path.
   stse_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CW          (CW)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_key       (req_key),
      .req_key_end   (req_key_end),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_has_value (rsp_has_value),
      .rsp_tally     (rsp_tally),
      .rsp_found     (rsp_found),
      .rsp_full_drop (rsp_full_drop),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

### sv/stse_checker.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine checker
// Port-level assertions on the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
module stse_checker #(
   parameter int TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF,
   parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [stse_pkg::VALUE_W-1:0] rsp_value,
   input logic                         rsp_has_value,
   input logic [CW-1:0]                rsp_tally,
   input logic                         rsp_found,
   input logic                         rsp_full_drop
);
   import stse_pkg::*;

   // An accepted request transaction blocks the one behind it; the stall rises in the cycle after acceptance.
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // A stalled transaction stays valid.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A result without a timestamp carries the all-ones value.
   a_none_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value |-> rsp_value == NONE_VALUE)
      else $error("empty result with a value");

   // A real timestamp is never negative and never reported with other flags.
   a_has_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_value |->
         !rsp_value[VALUE_W-1] && !rsp_found && !rsp_full_drop && rsp_tally == '0)
      else $error("timestamp result with stray fields");

   // Tally never exceeds the table depth.
   a_tally_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tally <= CW'(TABLE_DEPTH))
      else $error("tally beyond table depth");

endmodule

bind sorted_timestamp_set_engine_core stse_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .CW          (CW)
) u_stse_checker (.*);

### verif/tb_sorted_timestamp_set_engine_core.sv
// ----------------------------------------------------------------------------
// Sorted timestamp set engine core testbench
// Drives requests against the core, predicts every result from a local copy
// of the sorted key table, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_sorted_timestamp_set_engine_core;
   import stse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH    = TABLE_DEPTH_DEF;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int WD_LIMIT = 20000;

   // Request codes with no defined operation.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 4'd10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 4'd15;

   // One expected response transaction.
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               has_value;
      logic [CNT_W-1:0]   tally;
      logic               found;
      logic               full_drop;
      logic               last;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [KEY_W-1:0]    req_key_end = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_value;
   logic                rsp_has_value;
   logic [CNT_W-1:0]    rsp_tally;
   logic                rsp_found;
   logic                rsp_full_drop;
   logic                rsp_last;

   // Predictor state.
   logic [KEY_W-1:0] table_keys[DEPTH];
   int               table_count = 0;
   answer_type       pending_answers[$];
   int               error_count = 0;
   int               idle_cycles = 0;
   bit               allow_gaps = 1'b1;

   sorted_timestamp_set_engine_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL sorted_timestamp_set_engine_core");
            $finish;
         end
      end
   end

   // Random stall bursts on the response side.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (allow_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response value=%h", rsp_value);
            error_count++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_value !== e.value) begin
               $error("value exp %h got %h", e.value, rsp_value);
               error_count++;
            end
            if (rsp_has_value !== e.has_value) begin
               $error("has_value exp %0d got %0d", e.has_value, rsp_has_value);
               error_count++;
            end
            if (rsp_tally !== e.tally) begin
               $error("tally exp %0d got %0d", e.tally, rsp_tally);
               error_count++;
            end
            if (rsp_found !== e.found) begin
               $error("found exp %0d got %0d", e.found, rsp_found);
               error_count++;
            end
            if (rsp_full_drop !== e.full_drop) begin
               $error("full_drop exp %0d got %0d", e.full_drop, rsp_full_drop);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   function automatic int first_at_or_above(logic [KEY_W-1:0] k);
      int i = 0;
      while (i < table_count && table_keys[i] < k) i++;
      return i;
   endfunction

   function automatic int first_past(logic [KEY_W-1:0] k);
      int i = 0;
      while (i < table_count && table_keys[i] <= k) i++;
      return i;
   endfunction

   function automatic void push_answer(bit has, logic [KEY_W-1:0] v, int tally, bit fnd,
                                       bit drop, bit lst);
      answer_type a;
      a.value     = has ? {1'b0, v} : NONE_VALUE;
      a.has_value = has;
      a.tally     = tally[CNT_W-1:0];
      a.found     = fnd;
      a.full_drop = drop;
      a.last      = lst;
      pending_answers.push_back(a);
   endfunction

   function automatic void push_span(int lo, int hi);
      if (hi > table_count) hi = table_count;
      if (lo >= hi) begin
         push_answer(0, '0, 0, 0, 0, 1);
      end else begin
         for (int i = lo; i < hi; i++) push_answer(1, table_keys[i], 0, 0, 0, i + 1 == hi);
      end
   endfunction

   // Updates the table copy and queues the responses for one request.
   function automatic void predict_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                           logic [KEY_W-1:0] ke);
      int p;
      case (f)
         FUNC_INSERT: begin
            p = first_at_or_above(k);
            if (p < table_count && table_keys[p] == k) begin
               push_answer(0, '0, 0, 0, 0, 1);
            end else if (table_count >= DEPTH) begin
               push_answer(0, '0, 0, 0, 1, 1);
            end else begin
               for (int i = table_count; i > p; i--) table_keys[i] = table_keys[i-1];
               table_keys[p] = k;
               table_count++;
               push_answer(0, '0, 0, 0, 0, 1);
            end
         end
         FUNC_REMOVE_BELOW: begin
            p = first_at_or_above(k);
            for (int i = p; i < table_count; i++) table_keys[i-p] = table_keys[i];
            table_count -= p;
            push_answer(0, '0, p, 0, 0, 1);
         end
         FUNC_LIST_BELOW: push_span(0, first_at_or_above(k));
         FUNC_LIST_RANGE: begin
            if (k > ke) push_answer(0, '0, 0, 0, 0, 1);
            else push_span(first_at_or_above(k), first_past(ke));
         end
         FUNC_NEAREST: begin
            p = first_at_or_above(k);
            if (table_count == 0) push_answer(0, '0, 0, 0, 0, 1);
            else if (p == 0) push_answer(1, table_keys[0], 0, 0, 0, 1);
            else if (p >= table_count) push_answer(1, table_keys[table_count-1], 0, 0, 0, 1);
            else if (k - table_keys[p-1] <= table_keys[p] - k)
               push_answer(1, table_keys[p-1], 0, 0, 0, 1);
            else push_answer(1, table_keys[p], 0, 0, 0, 1);
         end
         FUNC_LATEST: begin
            if (table_count == 0) push_answer(0, '0, 0, 0, 0, 1);
            else push_answer(1, table_keys[table_count-1], 0, 0, 0, 1);
         end
         FUNC_EARLIEST: begin
            if (table_count == 0) push_answer(0, '0, 0, 0, 0, 1);
            else push_answer(1, table_keys[0], 0, 0, 0, 1);
         end
         FUNC_COUNT: push_answer(0, '0, table_count, 0, 0, 1);
         FUNC_CLEAR: begin
            table_count = 0;
            push_answer(0, '0, 0, 0, 0, 1);
         end
         FUNC_CONTAINS: begin
            p = first_at_or_above(k);
            push_answer(0, '0, 0, p < table_count && table_keys[p] == k, 0, 1);
         end
         default: push_answer(0, '0, 0, 0, 0, 1);
      endcase
   endfunction

   // Sends one request transaction and records its expected responses.
   // Valid stays high into the next call; the caller drops it after the last one.
   task automatic send_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                               logic [KEY_W-1:0] ke = '0);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_key     <= k;
      req_key_end <= ke;
      do @(posedge clock); while (req_stall);
      predict_request(f, k, ke);
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   // Small keys so lookups, duplicates and ties actually hit.
   function automatic logic [KEY_W-1:0] near_key();
      return KEY_W'($urandom_range(0, 200));
   endfunction

   task automatic test_empty_table();
      send_request(FUNC_NEAREST, '1);
      send_request(FUNC_LATEST, '0);
      send_request(FUNC_EARLIEST, '0);
      send_request(FUNC_COUNT, '0);
      send_request(FUNC_LIST_BELOW, '1);
      send_request(FUNC_LIST_RANGE, '0, '1);
      send_request(FUNC_CONTAINS, '0);
   endtask

   task automatic test_directed_ops();
      send_request(FUNC_INSERT, '0);
      send_request(FUNC_INSERT, '1);
      send_request(FUNC_INSERT, 63'd10);
      send_request(FUNC_INSERT, 63'd20);
      send_request(FUNC_INSERT, 63'd10);
      // The tie between 10 and 20 goes to the lower key.
      send_request(FUNC_NEAREST, 63'd15);
      send_request(FUNC_NEAREST, 63'd16);
      send_request(FUNC_LIST_RANGE, 63'd20, 63'd5);
      send_request(FUNC_LIST_RANGE, 63'd10, 63'd20);
      send_request(FUNC_LIST_BELOW, 63'd0);
      send_request(FUNC_CONTAINS, '1);
      send_request(FUNC_REMOVE_BELOW, 63'd11);
      send_request(FUNC_COUNT, '0);
      send_request(FUNC_UNUSED_FIRST, '1, '1);
      send_request(FUNC_UNUSED_LAST, '0, '0);
      send_request(FUNC_CLEAR, '0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < DEPTH; i++) send_request(FUNC_INSERT, 63'(i * 3 + 1));
      send_request(FUNC_INSERT, 63'd4);
      send_request(FUNC_INSERT, '0);
      send_request(FUNC_LIST_BELOW, '1);
      send_request(FUNC_COUNT, '0);
      send_request(FUNC_REMOVE_BELOW, '1);
      send_request(FUNC_COUNT, '0);
   endtask

   task automatic test_random_mix(int n);
      logic [FUNC_W-1:0] f;
      logic [KEY_W-1:0]  k, ke;
      for (int i = 0; i < n; i++) begin
         k  = $urandom_range(0, 3) == 0 ? rand_key() : near_key();
         ke = $urandom_range(0, 3) == 0 ? rand_key() : near_key();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: f = FUNC_INSERT;
            7:  f = FUNC_REMOVE_BELOW;
            8:  f = FUNC_LIST_BELOW;
            9, 10: f = FUNC_LIST_RANGE;
            11, 12: f = FUNC_NEAREST;
            13: f = FUNC_LATEST;
            14: f = FUNC_EARLIEST;
            15: f = FUNC_COUNT;
            16: f = $urandom_range(0, 7) == 0 ? FUNC_CLEAR : FUNC_COUNT;
            17, 18: f = FUNC_CONTAINS;
            default: f = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
         endcase
         send_request(f, k, ke);
      end
   endtask

   initial begin
      int guard;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_ops();
      test_full_table();
      test_random_mix(120);
      allow_gaps = 1'b0;
      test_random_mix(50);
      req_valid <= 1'b0;
      guard = 0;
      while (pending_answers.size() != 0 && guard < WD_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("PASS sorted_timestamp_set_engine_core");
      end else begin
         $display("FAIL sorted_timestamp_set_engine_core");
      end
      $finish;
   end

endmodule

### sim.f
sv/stse_pkg.sv
sv/stse_ctrl.sv
sv/stse_datapath.sv
sv/sorted_timestamp_set_engine_core.sv
sv/stse_checker.sv
verif/tb_sorted_timestamp_set_engine_core.sv
